// ===== hdl/htta_pkg.sv =====
// Types and codes shared by the handle table and its slot evaluation unit.
package htta_pkg;

    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_CREATE = 3'd1;
    localparam logic [2:0] OP_GET    = 3'd2;
    localparam logic [2:0] OP_DELETE = 3'd3;
    localparam logic [2:0] OP_LIST   = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] req_timeout;
        logic [31:0] req_id;
    } htta_in_t;

    typedef struct packed {
        logic [1:0]  result_status;
        logic [31:0] result_id;
        logic        result_one_off;
        logic [15:0] result_timeout;
        logic        last_of_run;
    } htta_out_t;

    typedef struct packed {
        logic [31:0] id;
        logic        one_off;
        logic [15:0] timeout;
        logic [31:0] accessed_at;
    } htta_entry_t;

    typedef struct packed {
        logic kill;
        logic alive;
        logic id_hit;
    } htta_eval_t;

endpackage

// ===== hdl/htta_slot_eval.sv =====
// Shared compare unit: ages one table entry and matches it against the requested id.
module htta_slot_eval import htta_pkg::*; (
    input  logic        slot_valid,
    input  htta_entry_t entry,
    input  logic [31:0] now_seconds,
    input  logic [31:0] req_id,
    output htta_eval_t  result
);

    logic [31:0] idle;

    assign idle = now_seconds - entry.accessed_at;

    always_comb begin
        result.kill   = slot_valid && !entry.one_off && (idle > {16'd0, entry.timeout});
        result.alive  = slot_valid && !result.kill;
        result.id_hit = result.alive && (entry.id == req_id);
    end

endmodule

// ===== hdl/handle_table_with_timeout_aging.sv =====
// Top level of the handle table with idle-timeout aging, its sequencer and entry memory.
//
// The block keeps TABLE_SLOTS handles, each with an id, a one-off flag, an idle timeout
// in seconds and the second of its last access. Every item with a defined opcode starts
// with one pass over the table through the single entry memory read port and a shared
// compare unit: one slot is read per cycle. During that pass expired entries are freed,
// and the lowest free slot, the lowest matching id and the last valid slot are found at
// the same time. A decide step then commits the operation; for every opcode but tick it
// first waits until any previous result has been taken and then loads the result
// register or, for a list over a table that is not empty, starts a second walk of the
// table instead. That walk skips free slots and presents each valid entry in turn, each
// held while the result register is occupied. Undefined opcodes are accepted and
// dropped without a pass. The valid bits reset at once, so there is no clearing pass
// after reset; the other entry fields are written before they are read.
module handle_table_with_timeout_aging import htta_pkg::*; #(
    parameter int TABLE_SLOTS = 64
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  htta_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output htta_out_t m_data
);

    localparam int IDX_W = $clog2(TABLE_SLOTS);
    localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TABLE_SLOTS - 1);
    localparam logic [CNT_W-1:0] END_CNT  = CNT_W'(TABLE_SLOTS);

    // Sequencer states.
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SCAN    = 3'd1;
    localparam logic [2:0] S_DRAIN   = 3'd2;
    localparam logic [2:0] S_DECIDE  = 3'd3;
    localparam logic [2:0] S_LST_RD  = 3'd4;
    localparam logic [2:0] S_LST_OUT = 3'd5;

    logic [2:0]             state_reg, state_next;
    logic [2:0]             op_reg, op_next;
    logic [15:0]            timeout_reg, timeout_next;
    logic [31:0]            req_id_reg, req_id_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   q_live_reg, q_live_next;
    logic [IDX_W-1:0]       q_idx_reg, q_idx_next;
    logic                   found_reg, found_next;
    logic [IDX_W-1:0]       slot_reg, slot_next;
    htta_entry_t            hit_reg, hit_next;
    logic                   any_reg, any_next;
    logic [IDX_W-1:0]       last_slot_reg, last_slot_next;
    logic [31:0]            next_handle_reg, next_handle_next;
    logic [31:0]            now_reg, now_next;
    logic [TABLE_SLOTS-1:0] valid_reg, valid_next;
    logic                   m_valid_reg, m_valid_next;
    htta_out_t              m_data_reg, m_data_next;

    // Entry memory: one write and one registered read per cycle.
    htta_entry_t      entry_mem_reg [TABLE_SLOTS];
    htta_entry_t      mem_q_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             mem_we;
    logic [IDX_W-1:0] wr_addr;
    htta_entry_t      wr_data;

    htta_eval_t       slot_eval;
    logic             out_free;
    logic [IDX_W-1:0] cnt_idx;

    assign cnt_idx  = cnt_reg[IDX_W-1:0];
    assign rd_addr  = cnt_idx;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            entry_mem_reg[wr_addr] <= wr_data;
        end
        mem_q_reg <= entry_mem_reg[rd_addr];
    end

    // The entry read in the previous cycle is aged and compared here.
    htta_slot_eval u_slot_eval (
        .slot_valid  (q_live_reg && valid_reg[q_idx_reg]),
        .entry       (mem_q_reg),
        .now_seconds (now_reg),
        .req_id      (req_id_reg),
        .result      (slot_eval)
    );

    always_comb begin
        state_next       = state_reg;
        op_next          = op_reg;
        timeout_next     = timeout_reg;
        req_id_next      = req_id_reg;
        cnt_next         = cnt_reg;
        q_live_next      = 1'b0;
        q_idx_next       = q_idx_reg;
        found_next       = found_reg;
        slot_next        = slot_reg;
        hit_next         = hit_reg;
        any_next         = any_reg;
        last_slot_next   = last_slot_reg;
        next_handle_next = next_handle_reg;
        now_next         = now_reg;
        valid_next       = valid_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_data_next      = m_data_reg;
        mem_we           = 1'b0;
        wr_addr          = slot_reg;
        wr_data          = hit_reg;

        // Outcome of the slot under evaluation during the aging pass.
        if (q_live_reg) begin
            if (slot_eval.kill) begin
                valid_next[q_idx_reg] = 1'b0;
            end
            if (slot_eval.alive) begin
                any_next       = 1'b1;
                last_slot_next = q_idx_reg;
            end
            if (!found_reg) begin
                if (op_reg == OP_CREATE && !slot_eval.alive) begin
                    found_next = 1'b1;
                    slot_next  = q_idx_reg;
                end else if ((op_reg == OP_GET || op_reg == OP_DELETE) && slot_eval.id_hit) begin
                    found_next = 1'b1;
                    slot_next  = q_idx_reg;
                    hit_next   = mem_q_reg;
                end
            end
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next      = s_data.opcode;
                    timeout_next = s_data.req_timeout;
                    req_id_next  = s_data.req_id;
                    cnt_next     = '0;
                    found_next   = 1'b0;
                    any_next     = 1'b0;
                    if (s_data.opcode == OP_TICK) begin
                        now_next = now_reg + 32'd1;
                    end
                    if (s_data.opcode <= OP_LIST) begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                q_live_next = 1'b1;
                q_idx_next  = cnt_idx;
                cnt_next    = cnt_reg + CNT_W'(1);
                if (cnt_reg == LAST_CNT) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                if (op_reg == OP_TICK) begin
                    state_next = S_IDLE;
                end else if (out_free) begin
                    m_valid_next                = 1'b1;
                    m_data_next                 = '0;
                    m_data_next.last_of_run     = 1'b1;
                    state_next                  = S_IDLE;
                    case (op_reg)
                        OP_CREATE: begin
                            if (!found_reg) begin
                                m_data_next.result_status = ST_FULL;
                            end else begin
                                mem_we                 = 1'b1;
                                wr_data.id             = next_handle_reg;
                                wr_data.one_off        = (timeout_reg == 16'd0);
                                wr_data.timeout        = timeout_reg;
                                wr_data.accessed_at    = now_reg;
                                valid_next[slot_reg]   = 1'b1;
                                next_handle_next       = next_handle_reg + 32'd1;
                                m_data_next.result_status  = ST_OK;
                                m_data_next.result_id      = next_handle_reg;
                                m_data_next.result_one_off = (timeout_reg == 16'd0);
                                m_data_next.result_timeout = timeout_reg;
                            end
                        end
                        OP_GET, OP_DELETE: begin
                            if (!found_reg) begin
                                m_data_next.result_status = ST_UNKNOWN;
                            end else begin
                                m_data_next.result_status  = ST_OK;
                                m_data_next.result_id      = hit_reg.id;
                                m_data_next.result_one_off = hit_reg.one_off;
                                m_data_next.result_timeout = hit_reg.timeout;
                                if (op_reg == OP_GET) begin
                                    mem_we              = 1'b1;
                                    wr_data.accessed_at = now_reg;
                                    if (hit_reg.one_off) begin
                                        valid_next[slot_reg] = 1'b0;
                                    end
                                end else begin
                                    valid_next[slot_reg] = 1'b0;
                                end
                            end
                        end
                        default: begin
                            // List: an empty table gives a single result, else walk again.
                            if (!any_reg) begin
                                m_data_next.result_status = ST_EMPTY;
                            end else begin
                                m_valid_next = m_valid_reg && !m_ready;
                                m_data_next  = m_data_reg;
                                cnt_next     = '0;
                                state_next   = S_LST_RD;
                            end
                        end
                    endcase
                end
            end
            S_LST_RD: begin
                if (cnt_reg == END_CNT) begin
                    state_next = S_IDLE;
                end else if (valid_reg[cnt_idx]) begin
                    state_next = S_LST_OUT;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_LST_OUT: begin
                if (out_free) begin
                    m_valid_next               = 1'b1;
                    m_data_next.result_status  = ST_OK;
                    m_data_next.result_id      = mem_q_reg.id;
                    m_data_next.result_one_off = mem_q_reg.one_off;
                    m_data_next.result_timeout = mem_q_reg.timeout;
                    m_data_next.last_of_run    = (cnt_idx == last_slot_reg);
                    cnt_next                   = cnt_reg + CNT_W'(1);
                    state_next = (cnt_idx == last_slot_reg) ? S_IDLE : S_LST_RD;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            q_live_reg      <= 1'b0;
            found_reg       <= 1'b0;
            any_reg         <= 1'b0;
            cnt_reg         <= '0;
            next_handle_reg <= 32'd1;
            now_reg         <= 32'd0;
            valid_reg       <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            q_live_reg      <= q_live_next;
            found_reg       <= found_next;
            any_reg         <= any_next;
            cnt_reg         <= cnt_next;
            next_handle_reg <= next_handle_next;
            now_reg         <= now_next;
            valid_reg       <= valid_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        timeout_reg   <= timeout_next;
        req_id_reg    <= req_id_next;
        q_idx_reg     <= q_idx_next;
        slot_reg      <= slot_next;
        hit_reg       <= hit_next;
        last_slot_reg <= last_slot_next;
        m_data_reg    <= m_data_next;
    end

    // A defined opcode always starts the aging pass.
    a_start_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.opcode <= OP_LIST) |=> (state_reg == S_SCAN))
        else $error("accepted item did not start the aging pass");

    // The compare unit only sees memory data during the pass.
    a_live_in_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        q_live_reg |-> (state_reg == S_SCAN || state_reg == S_DRAIN))
        else $error("slot evaluated outside the aging pass");

    // The list walk only ever presents valid entries.
    a_list_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LST_OUT) |-> valid_reg[cnt_idx])
        else $error("list walk stopped on a free slot");

    // A successful create consumes exactly one id.
    a_handle_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DECIDE && out_free && op_reg == OP_CREATE && found_reg)
        |=> (next_handle_reg == $past(next_handle_reg) + 32'd1))
        else $error("next handle did not advance on create");

endmodule

// ===== dv/htta_checker.sv =====
// Channel monitor that predicts the handle table's results and compares them.
module htta_checker import htta_pkg::*; #(
    parameter int SLOTS = 64
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  htta_in_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  htta_out_t m_data,
    output int        mismatches,
    output int        results_due
);

    logic        slot_busy [SLOTS];
    htta_entry_t slot_rec  [SLOTS];
    logic [31:0] next_handle_id;
    logic [31:0] seconds_now;
    htta_out_t   due_results [$];
    int          err_count = 0;

    assign mismatches = err_count;

    function automatic void queue_result(logic [1:0] status, int slot, logic last);
        htta_out_t r;
        r = '0;
        r.result_status = status;
        r.last_of_run   = last;
        if (slot >= 0) begin
            r.result_id      = slot_rec[slot].id;
            r.result_one_off = slot_rec[slot].one_off;
            r.result_timeout = slot_rec[slot].timeout;
        end
        due_results = {due_results, r};
    endfunction

    // Entries that are not one-off and have been idle beyond their timeout are dropped.
    function automatic void expire_idle();
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_busy[i] && !slot_rec[i].one_off &&
                (seconds_now - slot_rec[i].accessed_at) > {16'h0, slot_rec[i].timeout}) begin
                slot_busy[i] = 1'b0;
            end
        end
    endfunction

    function automatic void predict_item(htta_in_t it);
        int hit;
        int last_busy;
        hit = -1;
        last_busy = -1;
        if (it.opcode > OP_LIST) return;
        if (it.opcode == OP_TICK) begin
            seconds_now = seconds_now + 32'd1;
            expire_idle();
            return;
        end
        expire_idle();
        case (it.opcode)
            OP_CREATE: begin
                for (int i = SLOTS - 1; i >= 0; i--) begin
                    if (!slot_busy[i]) hit = i;
                end
                if (hit < 0) begin
                    queue_result(ST_FULL, -1, 1'b1);
                end else begin
                    slot_busy[hit]            = 1'b1;
                    slot_rec[hit].id          = next_handle_id;
                    slot_rec[hit].one_off     = (it.req_timeout == 16'h0);
                    slot_rec[hit].timeout     = it.req_timeout;
                    slot_rec[hit].accessed_at = seconds_now;
                    next_handle_id            = next_handle_id + 32'd1;
                    queue_result(ST_OK, hit, 1'b1);
                end
            end
            OP_GET, OP_DELETE: begin
                for (int i = SLOTS - 1; i >= 0; i--) begin
                    if (slot_busy[i] && slot_rec[i].id == it.req_id) hit = i;
                end
                if (hit < 0) begin
                    queue_result(ST_UNKNOWN, -1, 1'b1);
                end else begin
                    queue_result(ST_OK, hit, 1'b1);
                    if (it.opcode == OP_GET) begin
                        slot_rec[hit].accessed_at = seconds_now;
                        if (slot_rec[hit].one_off) slot_busy[hit] = 1'b0;
                    end else begin
                        slot_busy[hit] = 1'b0;
                    end
                end
            end
            OP_LIST: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_busy[i]) last_busy = i;
                end
                if (last_busy < 0) begin
                    queue_result(ST_EMPTY, -1, 1'b1);
                end else begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (slot_busy[i]) queue_result(ST_OK, i, i == last_busy);
                    end
                end
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            err_count++;
        end
    endfunction

    always @(posedge aclk) begin : watch
        htta_out_t want;
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                slot_busy[i] = 1'b0;
                slot_rec[i]  = '0;
            end
            next_handle_id = 32'd1;
            seconds_now    = 32'd0;
            due_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    $error("result with no expectation waiting: id 0x%0h status %0d",
                           m_data.result_id, m_data.result_status);
                    err_count++;
                end else begin
                    want = due_results.pop_front();
                    check_field("result_status", 32'(want.result_status),
                                32'(m_data.result_status));
                    check_field("result_id", want.result_id, m_data.result_id);
                    check_field("result_one_off", 32'(want.result_one_off),
                                32'(m_data.result_one_off));
                    check_field("result_timeout", 32'(want.result_timeout),
                                32'(m_data.result_timeout));
                    check_field("last_of_run", 32'(want.last_of_run),
                                32'(m_data.last_of_run));
                end
            end
            if (s_valid && s_ready) predict_item(s_data);
        end
        results_due <= due_results.size();
    end

endmodule

// ===== dv/tb_handle_table_with_timeout_aging.sv =====
// Top of the handle table testbench: clock, reset, stimulus and the final verdict.
module tb_handle_table_with_timeout_aging;
    import htta_pkg::*;

    localparam int SLOTS = 64;

    // Opcodes above list are reserved; the block must swallow them silently.
    localparam logic [2:0] OP_RSVD_FIRST = 3'd5;
    localparam logic [2:0] OP_RSVD_LAST  = 3'd7;

    // A full list walk with every result stalled for a while stays well inside this.
    localparam int SETTLE_CYCLES = 6 * SLOTS + 100;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    htta_in_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    htta_out_t m_data;

    int mismatches;
    int results_due;

    // While this is set neither side idles, giving one long unbroken stretch.
    logic steady = 1'b0;

    // Rough count of handles handed out so far; creates that meet a full table make
    // it run slightly ahead, which only widens the spread of ids that are looked up.
    logic [31:0] last_handle = 32'd0;

    always #5 aclk = ~aclk;

    handle_table_with_timeout_aging #(
        .TABLE_SLOTS(SLOTS)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    htta_checker #(
        .SLOTS(SLOTS)
    ) i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .mismatches  (mismatches),
        .results_due (results_due)
    );

    // The result side stalls at random, with a chance of twelve in a hundred, but never while steady is set.
    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= 12);
    end

    // Offers one item and returns at the edge on which it is taken. Valid is only
    // lowered when an idle gap is inserted in front of the next item, so that a
    // back-to-back item never sees valid dropped and raised within one time step.
    task automatic send_item(logic [2:0] op, logic [15:0] tmo, logic [31:0] id);
        if (!steady) begin
            while ($urandom_range(0, 99) < 12) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_data.opcode      <= op;
        s_data.req_timeout <= tmo;
        s_data.req_id      <= id;
        s_valid            <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (op == OP_CREATE) last_handle = last_handle + 32'd1;
    endtask

    // Holds the sender back until every predicted result has been taken. The first
    // edge lets the monitor's count take in an item accepted at the edge just gone.
    task automatic hold_until_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
    endtask

    // Timeouts favour small values so that ticks really do expire entries, with
    // one-off entries, the widest timeout and fully random values mixed in.
    function automatic logic [15:0] pick_timeout();
        int roll;
        roll = $urandom_range(0, 15);
        if (roll < 2) return 16'h0000;
        if (roll == 2) return 16'hFFFF;
        if (roll < 6) return 16'($urandom);
        return 16'($urandom_range(1, 6));
    endfunction

    // Most lookups aim at recently issued handles, so that gets and deletes find live
    // entries; the rest miss on purpose.
    function automatic logic [31:0] pick_id();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll == 0) return 32'h0000_0000;
        if (roll == 1) return 32'hFFFF_FFFF;
        if (roll < 4) return $urandom;
        return last_handle - 32'($urandom_range(0, 10));
    endfunction

    // One random item; 'counted' is cleared for reserved opcodes, which cause nothing.
    task automatic send_mixed(output bit counted);
        int          roll;
        logic [2:0]  op;
        roll = $urandom_range(0, 99);
        counted = 1'b1;
        if (roll < 18) begin
            op = OP_TICK;
        end else if (roll < 48) begin
            op = OP_CREATE;
        end else if (roll < 73) begin
            op = OP_GET;
        end else if (roll < 88) begin
            op = OP_DELETE;
        end else if (roll < 95) begin
            op = OP_LIST;
        end else begin
            op = 3'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
            counted = 1'b0;
        end
        send_item(op, pick_timeout(), pick_id());
    endtask

    initial begin : stimulus
        int sent;
        bit counted;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed opening. An empty table answers a list with the empty status and
        // lookups of the extreme ids with unknown id.
        send_item(OP_LIST, 16'h0000, 32'h0000_0000);
        send_item(OP_GET, 16'hFFFF, 32'h0000_0000);
        send_item(OP_DELETE, 16'h0000, 32'hFFFF_FFFF);

        // A one-off entry, the widest timeout, and two short ones that age apart.
        send_item(OP_CREATE, 16'h0000, 32'hFFFF_FFFF);
        send_item(OP_CREATE, 16'hFFFF, 32'h0000_0000);
        send_item(OP_CREATE, 16'h0001, $urandom);
        send_item(OP_CREATE, 16'h0002, $urandom);
        send_item(OP_LIST, 16'($urandom), $urandom);

        // A get frees the one-off entry, so the second get no longer finds it.
        send_item(OP_GET, 16'h0000, 32'd1);
        send_item(OP_GET, 16'h0000, 32'd1);

        // After two seconds the entry with a one-second timeout has expired, while the
        // two-second one is exactly at its limit and survives to be refreshed.
        send_item(OP_TICK, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(OP_TICK, 16'h0000, 32'h0000_0000);
        send_item(OP_GET, 16'($urandom), 32'd3);
        send_item(OP_GET, 16'($urandom), 32'd4);

        // Reserved opcodes with arbitrary fields must change nothing.
        send_item(OP_RSVD_FIRST, 16'($urandom), $urandom);
        send_item(OP_RSVD_LAST, 16'($urandom), $urandom);
        send_item(OP_TICK, 16'($urandom), $urandom);

        // Delete succeeds once, then the id is unknown.
        send_item(OP_DELETE, 16'($urandom), 32'd2);
        send_item(OP_DELETE, 16'($urandom), 32'd2);

        // A new one-off entry takes the lowest free slot and never ages out.
        send_item(OP_CREATE, 16'h0000, $urandom);
        send_item(OP_TICK, 16'($urandom), $urandom);
        send_item(OP_TICK, 16'($urandom), $urandom);
        send_item(OP_LIST, 16'($urandom), $urandom);
        send_item(OP_CREATE, 16'h8000, 32'hFFFF_FFFF);
        send_item(OP_DELETE, 16'h7FFF, 32'd5);

        // The sender waits here until the table has answered everything.
        hold_until_drained();

        // General mix: creates, lookups, deletes, lists and ticks with random gaps.
        sent = 0;
        while (sent < 130) begin
            send_mixed(counted);
            sent += counted;
        end
        hold_until_drained();

        // Unbroken stretch that overfills the table with long-lived entries, so that
        // the last creates are refused, then lists the full table and picks at it.
        steady = 1'b1;
        for (int i = 0; i < SLOTS + 4; i++) begin
            send_item(OP_CREATE, 16'($urandom_range(100, 65535)), $urandom);
        end
        send_item(OP_LIST, 16'($urandom), $urandom);
        for (int i = 0; i < 12; i++) begin
            send_item(($urandom_range(0, 1) != 0) ? OP_GET : OP_DELETE,
                      16'($urandom), last_handle - 32'($urandom_range(0, SLOTS + 8)));
        end
        send_item(OP_LIST, 16'($urandom), $urandom);
        steady = 1'b0;
        hold_until_drained();

        // Second mix on a crowded table, idling again.
        sent = 0;
        while (sent < 50) begin
            send_mixed(counted);
            sent += counted;
        end

        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Guard against a hung handshake: far beyond the slowest legal run.
    initial begin : watchdog
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/htta_pkg.sv
hdl/htta_slot_eval.sv
hdl/handle_table_with_timeout_aging.sv
dv/htta_checker.sv
dv/tb_handle_table_with_timeout_aging.sv
